// ===== rtl/core/prd_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority request dispatcher package
// Shared constants, item types and sequencer states of the dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

    localparam int BUFFER_SLOTS = 8;
    localparam int NUM_DEVICES  = 8;

    localparam int SLOT_W = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
    localparam int DEV_W  = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int CNT_W  = $clog2(NUM_DEVICES + 1);

    localparam logic       KIND_WRITE       = 1'b0;
    localparam logic       KIND_ASSIGN      = 1'b1;
    localparam logic [3:0] CFG_COUNT_RESET  = 4'd8;

    typedef struct packed {
        logic        kind;
        logic [2:0]  slot_index;
        logic [15:0] request_id;
        logic [1:0]  priority_req;
        logic [31:0] time_entered;
        logic [7:0]  device_free_mask;
        logic [31:0] assign_time;
    } in_item_t;

    typedef struct packed {
        logic        assigned;
        logic [15:0] out_request_id;
        logic [2:0]  device_id;
        logic [31:0] out_time;
    } out_item_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  pri;
        logic [31:0] entry_time;
    } slot_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEV_SCAN,
        ST_SLOT_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/prd_slot_table.sv =====
// ----------------------------------------------------------------------------
// Slot table
// Request slots with valid bits, one write port, one clear port, one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_slot_table
    import prd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    wr_en,
    input  wire logic [SLOT_W-1:0]       wr_idx,
    input  wire slot_entry_t             wr_entry,
    input  wire logic                    clr_en,
    input  wire logic [SLOT_W-1:0]       clr_idx,
    input  wire logic [SLOT_W-1:0]       rd_idx,
    output      slot_entry_t             rd_entry,
    output      logic                    rd_valid,
    output      logic [BUFFER_SLOTS-1:0] valid_vec
);

    slot_entry_t             entry_reg [BUFFER_SLOTS];
    logic [BUFFER_SLOTS-1:0] valid_reg;
    logic [BUFFER_SLOTS-1:0] valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        if (clr_en)
        begin
            valid_next[clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_entry;
        end
    end

    assign rd_entry  = entry_reg[rd_idx];
    assign rd_valid  = valid_reg[rd_idx];
    assign valid_vec = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/prd_compare.sv =====
// ----------------------------------------------------------------------------
// Selection compare unit
// Decides whether the slot under scan replaces the best slot found so far.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_compare
    import prd_pkg::*;
(
    input  wire logic        cand_valid,
    input  wire slot_entry_t cand,
    input  wire logic        have_best,
    input  wire slot_entry_t best,
    output      logic        take
);

    logic pri_gt;
    logic pri_eq;
    logic time_gt;

    assign pri_gt  = cand.pri > best.pri;
    assign pri_eq  = cand.pri == best.pri;
    assign time_gt = cand.entry_time > best.entry_time;

    // Strict compares keep the lower slot on a full tie.
    assign take = cand_valid && (!have_best || pri_gt || (pri_eq && time_gt));

endmodule

`default_nettype wire

// ===== rtl/core/priority_request_dispatcher.sv =====
// ----------------------------------------------------------------------------
// Priority request dispatcher
// Buffers requests in a slot table and hands the best one to a free device
// chosen round-robin from a rotating pointer.
// ----------------------------------------------------------------------------
//   Channel   Handshake                 Payload
//   in        in_valid / in_ready       in_item (in_item_t)
//   out       out_valid / out_ready     out_item (out_item_t)
//   cfg       cfg_wr_en                 cfg_wr_data (device count)
//
//   A write item goes from idle to the finish state, as does an assign item
// when the table is empty. Otherwise it steps the n-device ring, finishing
// if no device is free, or on the first free device scans every slot of
// the table and then finishes. The device ring and the slot table are each
// walked one entry per cycle; only the slot scan uses the compare unit.
// Reset clears the valid bits and the device pointer at once. A result
// held at the output stalls only the final step of the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_request_dispatcher
    import prd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire in_item_t   in_item,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      out_item_t  out_item,
    input  wire logic       cfg_wr_en,
    input  wire logic [3:0] cfg_wr_data
);

    state_t             state_reg, state_next;
    logic [DEV_W-1:0]   pointer_reg, pointer_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [7:0]         mask_reg, mask_next;
    logic [31:0]        time_reg, time_next;
    logic [DEV_W-1:0]   dev_reg, dev_next;
    logic               have_best_reg, have_best_next;
    slot_entry_t        best_reg, best_next;
    logic [SLOT_W-1:0]  best_idx_reg, best_idx_next;
    out_item_t          res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;
    logic [3:0]         cfg_count_reg;

    logic [CNT_W-1:0]        ring_n;
    logic [CNT_W-1:0]        p_inc;
    logic [DEV_W-1:0]        p_adv;
    logic                    dev_free;
    logic                    tbl_wr_en;
    logic                    tbl_clr_en;
    logic [SLOT_W-1:0]       tbl_clr_idx;
    slot_entry_t             wr_entry;
    slot_entry_t             rd_entry;
    logic                    rd_valid;
    logic [BUFFER_SLOTS-1:0] valid_vec;
    logic                    take;
    slot_entry_t             win_entry;
    logic [SLOT_W-1:0]       win_idx;
    logic                    write_in_range;

    assign wr_entry.id         = in_item.request_id;
    assign wr_entry.pri        = in_item.priority_req;
    assign wr_entry.entry_time = in_item.time_entered;
    assign write_in_range      = 32'(in_item.slot_index) < BUFFER_SLOTS;

    prd_slot_table u_slot_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (tbl_wr_en),
        .wr_idx   (SLOT_W'(in_item.slot_index)),
        .wr_entry (wr_entry),
        .clr_en   (tbl_clr_en),
        .clr_idx  (tbl_clr_idx),
        .rd_idx   (idx_reg),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .valid_vec(valid_vec)
    );

    prd_compare u_compare (
        .cand_valid(rd_valid),
        .cand      (rd_entry),
        .have_best (have_best_reg),
        .best      (best_reg),
        .take      (take)
    );

    always_comb
    begin
        if (cfg_count_reg == 4'd0)
        begin
            ring_n = CNT_W'(1);
        end
        else if (32'(cfg_count_reg) > NUM_DEVICES)
        begin
            ring_n = CNT_W'(NUM_DEVICES);
        end
        else
        begin
            ring_n = CNT_W'(cfg_count_reg);
        end
    end

    assign p_inc    = CNT_W'(pointer_reg) + CNT_W'(1);
    assign p_adv    = (p_inc >= ring_n) ? '0 : DEV_W'(p_inc);
    assign dev_free = 1'(mask_reg >> pointer_reg);

    assign win_entry = take ? rd_entry : best_reg;
    assign win_idx   = take ? idx_reg : best_idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        pointer_next   = pointer_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        time_next      = time_reg;
        dev_next       = dev_reg;
        have_best_next = have_best_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        tbl_wr_en      = 1'b0;
        tbl_clr_en     = 1'b0;
        tbl_clr_idx    = win_idx;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next = '0;
                    if (in_item.kind == KIND_WRITE)
                    begin
                        tbl_wr_en  = write_in_range;
                        state_next = ST_FINISH;
                    end
                    else if (!(|valid_vec))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mask_next    = in_item.device_free_mask;
                        time_next    = in_item.assign_time;
                        pointer_next = (CNT_W'(pointer_reg) < ring_n) ? pointer_reg : '0;
                        cnt_next     = '0;
                        state_next   = ST_DEV_SCAN;
                    end
                end
            end
            ST_DEV_SCAN:
            begin
                pointer_next = p_adv;
                if (dev_free)
                begin
                    dev_next       = pointer_reg;
                    idx_next       = '0;
                    have_best_next = 1'b0;
                    state_next     = ST_SLOT_SCAN;
                end
                else if (cnt_reg == ring_n - CNT_W'(1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SLOT_SCAN:
            begin
                if (take)
                begin
                    best_next      = rd_entry;
                    best_idx_next  = idx_reg;
                    have_best_next = 1'b1;
                end
                if (idx_reg == SLOT_W'(BUFFER_SLOTS - 1))
                begin
                    tbl_clr_en              = 1'b1;
                    res_next.assigned       = 1'b1;
                    res_next.out_request_id = win_entry.id;
                    res_next.device_id      = 3'(dev_reg);
                    res_next.out_time       = time_reg;
                    state_next              = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_item_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pointer_reg   <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_count_reg <= CFG_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pointer_reg   <= pointer_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            have_best_reg <= have_best_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cfg_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg     <= mask_next;
        time_reg     <= time_next;
        dev_reg      <= dev_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/prd_checker.sv =====
// ----------------------------------------------------------------------------
// Dispatcher port checker
// Port-level properties of the dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_checker
    import prd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire out_item_t  out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("Stalled result item changed or dropped.");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.assigned |->
            out_item.out_request_id == 16'd0 && out_item.device_id == 3'd0 &&
            out_item.out_time == 32'd0)
        else $error("Unassigned result item carries nonzero fields.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input ready directly after an accepted item.");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("Result item appeared without a preceding busy cycle.");

endmodule

bind priority_request_dispatcher prd_checker u_prd_checker (.*);

`default_nettype wire
